[rtl/sacl_pkg.sv]
// sacl_pkg: shared types and constants for the set-associative LRU cache model.
// Used by every module under rtl/. No dependencies.
`timescale 1ns / 1ps

package sacl_pkg;

  localparam int TOTAL_W = 32;
  localparam int ADDR_W  = 64;

  // register indexes on the configuration port
  localparam logic [1:0] REG_SET_BITS = 2'd0;
  localparam logic [1:0] REG_OFF_BITS = 2'd1;
  localparam logic [1:0] REG_WAYS     = 2'd2;

  localparam logic [3:0] RST_SET_BITS = 4'd4;
  localparam logic [5:0] RST_OFF_BITS = 6'd4;
  localparam logic [3:0] RST_WAYS     = 4'd1;

  localparam logic [1:0] MODE_MODIFY = 2'd2;

  localparam logic [1:0] OUT_HIT   = 2'd0;
  localparam logic [1:0] OUT_FILL  = 2'd1;
  localparam logic [1:0] OUT_EVICT = 2'd2;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  typedef struct packed {
    logic [3:0] set_bits;
    logic [5:0] off_bits;
    logic [3:0] ways;
  } cfg_t;

  typedef struct packed {
    logic               valid;
    logic [1:0]         outcome;
    logic               last;
    logic [TOTAL_W-1:0] hits;
    logic [TOTAL_W-1:0] misses;
    logic [TOTAL_W-1:0] evictions;
  } res_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SPLIT,
    ST_META,
    ST_SCAN,
    ST_UPDATE,
    ST_EMIT
  } state_t;

endpackage

[rtl/sacl_cfg.sv]
// sacl_cfg: APB-style register file for set bits, offset bits and ways in use.
// Depends on sacl_pkg.
`timescale 1ns / 1ps

module sacl_cfg
  import sacl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic       wr_en;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[3:2];
  assign wr_en  = psel & penable & pwrite;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_SET_BITS: cfg_nxt.set_bits = pwdata[3:0];
        REG_OFF_BITS: cfg_nxt.off_bits = pwdata[5:0];
        REG_WAYS:     cfg_nxt.ways     = pwdata[3:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SET_BITS: prdata = {28'd0, cfg_r.set_bits};
      REG_OFF_BITS: prdata = {26'd0, cfg_r.off_bits};
      REG_WAYS:     prdata = {28'd0, cfg_r.ways};
      default:      prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.set_bits <= RST_SET_BITS;
      cfg_r.off_bits <= RST_OFF_BITS;
      cfg_r.ways     <= RST_WAYS;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

[rtl/sacl_split.sv]
// sacl_split: splits an address into set index and tag under the current config.
// Depends on sacl_pkg.
`timescale 1ns / 1ps

module sacl_split
  import sacl_pkg::*;
#(
  parameter int MAX_SET_BITS = 8
) (
  input  logic [ADDR_W-1:0] addr,
  input  cfg_t              cfg,
  output logic [((MAX_SET_BITS > 0) ? MAX_SET_BITS : 1)-1:0] set_idx,
  output logic [ADDR_W-1:0] tag
);

  localparam int SW = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam logic [3:0] MAX_SB = 4'(MAX_SET_BITS);

  logic [3:0]        sb;
  logic [ADDR_W-1:0] shifted;
  logic [SW-1:0]     mask;
  logic [6:0]        split;

  always_comb begin
    sb      = (cfg.set_bits > MAX_SB) ? MAX_SB : cfg.set_bits;
    shifted = addr >> cfg.off_bits;
    mask    = ~({SW{1'b1}} << sb);
    set_idx = shifted[SW-1:0] & mask;
    split   = {3'd0, sb} + {1'b0, cfg.off_bits};
    tag     = split[6] ? '0 : (addr >> split[5:0]);
  end

endmodule

[rtl/sacl_core.sv]
// sacl_core: lookup sequencer. Holds the tag and LRU metadata memories and
// scans one way per cycle through a single tag compare. Depends on sacl_pkg, sacl_split.
`timescale 1ns / 1ps

module sacl_core
  import sacl_pkg::*;
#(
  parameter int MAX_SET_BITS = 8,
  parameter int MAX_WAYS     = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_mode,
  input  logic [ADDR_W-1:0] in_addr,
  output res_t              res,
  input  logic              res_ready
);

  localparam int SW     = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int SETS   = 1 << MAX_SET_BITS;
  localparam int WW     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int AW     = WW;
  localparam int WCW    = $clog2(MAX_WAYS + 1);
  localparam int MW     = MAX_WAYS * (1 + AW);
  localparam int TDEPTH = 1 << (SW + WW);

  state_t state_r, state_nxt;

  logic [ADDR_W-1:0]  addr_r, addr_nxt;
  logic               modify_r, modify_nxt;
  logic               second_r, second_nxt;
  logic [SW-1:0]      set_r, set_nxt;
  logic [ADDR_W-1:0]  tag_r, tag_nxt;
  logic [WW-1:0]      wc_r, wc_nxt;
  logic [SW-1:0]      clr_r, clr_nxt;
  logic               hit_r, hit_nxt;
  logic [WW-1:0]      hit_way_r, hit_way_nxt;
  logic               free_found_r, free_found_nxt;
  logic [WW-1:0]      free_way_r, free_way_nxt;
  logic [AW-1:0]      oldest_r, oldest_nxt;
  logic [WW-1:0]      victim_r, victim_nxt;
  logic [1:0]         outcome_r, outcome_nxt;
  logic [TOTAL_W-1:0] hits_r, hits_nxt;
  logic [TOTAL_W-1:0] misses_r, misses_nxt;
  logic [TOTAL_W-1:0] evicts_r, evicts_nxt;

  logic [MW-1:0]      meta_mem [SETS];
  logic [MW-1:0]      meta_rd_r;
  logic               meta_we;
  logic [SW-1:0]      meta_waddr;
  logic [MW-1:0]      meta_wdata;

  logic [ADDR_W-1:0]  tag_mem [TDEPTH];
  logic [ADDR_W-1:0]  tag_rd_r;
  logic               tag_we;
  logic [WW-1:0]      rd_way;
  logic [WW-1:0]      tw;

  logic [SW-1:0]      split_set;
  logic [ADDR_W-1:0]  split_tag;

  logic [MAX_WAYS-1:0] valid_v;
  logic [AW-1:0]       age_v [MAX_WAYS];
  logic [MAX_WAYS-1:0] valid_w;
  logic [AW-1:0]       age_w [MAX_WAYS];
  logic [4:0]          ways_raw;
  logic [WCW-1:0]      ways_eff;
  logic                cur_valid;
  logic [AW-1:0]       cur_age;
  logic                match;
  logic                last_way;
  logic                old_inf;
  logic [AW-1:0]       old_age;

  sacl_split #(.MAX_SET_BITS(MAX_SET_BITS)) u_split (
    .addr    (addr_r),
    .cfg     (cfg),
    .set_idx (split_set),
    .tag     (split_tag)
  );

  always_comb begin
    ways_raw = {1'b0, cfg.ways};
    if (ways_raw == 5'd0) begin
      ways_raw = 5'd1;
    end else if (ways_raw > 5'(MAX_WAYS)) begin
      ways_raw = 5'(MAX_WAYS);
    end
    ways_eff = WCW'(ways_raw);
  end

  always_comb begin
    valid_v = meta_rd_r[MAX_WAYS-1:0];
    for (int j = 0; j < MAX_WAYS; j++) begin
      age_v[j] = meta_rd_r[MAX_WAYS + j*AW +: AW];
    end
  end

  assign cur_valid = valid_v[wc_r];
  assign cur_age   = age_v[wc_r];
  assign match     = cur_valid && (tag_rd_r == tag_r);
  assign last_way  = (WCW'(wc_r) == (ways_eff - 1'b1));
  assign tw        = hit_r ? hit_way_r : (free_found_r ? free_way_r : victim_r);
  assign old_inf   = !valid_v[tw];
  assign old_age   = age_v[tw];

  // LRU update: the touched way becomes youngest and younger valid ways age by one
  always_comb begin
    for (int j = 0; j < MAX_WAYS; j++) begin
      valid_w[j] = valid_v[j];
      age_w[j]   = age_v[j];
      if (WW'(j) == tw) begin
        valid_w[j] = 1'b1;
        age_w[j]   = '0;
      end else if ((WCW'(j) < ways_eff) && valid_v[j] && (old_inf || (age_v[j] < old_age))) begin
        age_w[j] = AW'(age_v[j] + 1'b1);
      end
    end
  end

  always_comb begin
    meta_wdata[MAX_WAYS-1:0] = valid_w;
    for (int j = 0; j < MAX_WAYS; j++) begin
      meta_wdata[MAX_WAYS + j*AW +: AW] = age_w[j];
    end
    if (state_r == ST_CLEAR) begin
      meta_wdata = '0;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    addr_nxt       = addr_r;
    modify_nxt     = modify_r;
    second_nxt     = second_r;
    set_nxt        = set_r;
    tag_nxt        = tag_r;
    wc_nxt         = wc_r;
    clr_nxt        = clr_r;
    hit_nxt        = hit_r;
    hit_way_nxt    = hit_way_r;
    free_found_nxt = free_found_r;
    free_way_nxt   = free_way_r;
    oldest_nxt     = oldest_r;
    victim_nxt     = victim_r;
    outcome_nxt    = outcome_r;
    hits_nxt       = hits_r;
    misses_nxt     = misses_r;
    evicts_nxt     = evicts_r;
    in_ready       = 1'b0;
    meta_we        = 1'b0;
    meta_waddr     = set_r;
    tag_we         = 1'b0;
    rd_way         = '0;
    res            = '0;
    res.outcome    = outcome_r;
    res.last       = !modify_r || second_r;
    res.hits       = hits_r;
    res.misses     = misses_r;
    res.evictions  = evicts_r;

    unique case (state_r)
      ST_CLEAR: begin
        meta_we    = 1'b1;
        meta_waddr = clr_r;
        clr_nxt    = SW'(clr_r + 1'b1);
        if (clr_r == SW'(SETS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          addr_nxt   = in_addr;
          modify_nxt = (in_mode == MODE_MODIFY);
          second_nxt = 1'b0;
          state_nxt  = ST_SPLIT;
        end
      end
      ST_SPLIT: begin
        set_nxt   = split_set;
        tag_nxt   = split_tag;
        state_nxt = ST_META;
      end
      ST_META: begin
        wc_nxt    = '0;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        rd_way = WW'(wc_r + 1'b1);
        if (wc_r == '0) begin
          free_found_nxt = !cur_valid;
          free_way_nxt   = '0;
          oldest_nxt     = cur_age;
          victim_nxt     = '0;
        end else begin
          if (!free_found_r && !cur_valid) begin
            free_found_nxt = 1'b1;
            free_way_nxt   = wc_r;
          end
          if (cur_age > oldest_r) begin
            oldest_nxt = cur_age;
            victim_nxt = wc_r;
          end
        end
        if (match) begin
          hit_nxt     = 1'b1;
          hit_way_nxt = wc_r;
          state_nxt   = ST_UPDATE;
        end else if (last_way) begin
          hit_nxt   = 1'b0;
          state_nxt = ST_UPDATE;
        end else begin
          wc_nxt = WW'(wc_r + 1'b1);
        end
      end
      ST_UPDATE: begin
        meta_we = 1'b1;
        if (hit_r) begin
          outcome_nxt = OUT_HIT;
          if (hits_r != TOTAL_MAX) hits_nxt = hits_r + 1'b1;
        end else begin
          tag_we = 1'b1;
          if (misses_r != TOTAL_MAX) misses_nxt = misses_r + 1'b1;
          if (free_found_r) begin
            outcome_nxt = OUT_FILL;
          end else begin
            outcome_nxt = OUT_EVICT;
            if (evicts_r != TOTAL_MAX) evicts_nxt = evicts_r + 1'b1;
          end
        end
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        res.valid = 1'b1;
        if (res_ready) begin
          if (modify_r && !second_r) begin
            second_nxt = 1'b1;
            state_nxt  = ST_META;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLEAR;
      clr_r    <= '0;
      hits_r   <= '0;
      misses_r <= '0;
      evicts_r <= '0;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      hits_r   <= hits_nxt;
      misses_r <= misses_nxt;
      evicts_r <= evicts_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r       <= addr_nxt;
    modify_r     <= modify_nxt;
    second_r     <= second_nxt;
    set_r        <= set_nxt;
    tag_r        <= tag_nxt;
    wc_r         <= wc_nxt;
    hit_r        <= hit_nxt;
    hit_way_r    <= hit_way_nxt;
    free_found_r <= free_found_nxt;
    free_way_r   <= free_way_nxt;
    oldest_r     <= oldest_nxt;
    victim_r     <= victim_nxt;
    outcome_r    <= outcome_nxt;
  end

  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[meta_waddr] <= meta_wdata;
    end
    if (state_r == ST_META) begin
      meta_rd_r <= meta_mem[set_r];
    end
  end

  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_mem[{set_r, tw}] <= tag_r;
    end
    tag_rd_r <= tag_mem[{set_r, rd_way}];
  end

endmodule

[rtl/set_assoc_cache_lru_sim.sv]
// set_assoc_cache_lru_sim: top level; stream ports, output register, config port.
// Depends on sacl_pkg, sacl_cfg, sacl_core.
`timescale 1ns / 1ps
// Usage:
//   Input stream: in_tdata carries the 64-bit byte address, in_tuser the mode
//   (load, store, modify). Output stream: out_tuser carries the outcome (hit,
//   fill, evict), out_tlast marks the final result of an access, out_tdata the
//   saturating hit, miss and eviction totals after that result.
//   A load or store gives one result, a modify two (the second always a hit).
//   A result passes the split, metadata read, tag scan and update states on its
//   way to the output register; the tag scan checks one way per cycle through a
//   single comparator and stops at the first hit or after the last way in use.
//   A modify's second result repeats the metadata read, tag scan and update.
//   in_tready is high only while the sequencer is idle.
//   After reset the metadata memory is cleared, one set per cycle, through all
//   2**MAX_SET_BITS sets with in_tready low; config writes are taken meanwhile.
//   Totals return to zero and registers to their defaults on reset.
//   A stalled receiver holds the output register; the core then waits with
//   its next result until the register frees, so no result is lost.
//   The user writes configuration through the APB-style port only while idle (unenforced).

module set_assoc_cache_lru_sim
  import sacl_pkg::*;
#(
  parameter int MAX_SET_BITS = 8,
  parameter int MAX_WAYS     = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [63:0] address
  input  logic [1:0]  in_tuser,   // [1:0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // [31:0] hit_total, [63:32] miss_total, [95:64] eviction_total
  output logic [1:0]  out_tuser,  // [1:0] outcome
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  cfg_t cfg;
  res_t res;
  logic res_ready;

  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  out_outcome_r;
  logic        out_last_r;
  logic [95:0] out_data_r;

  sacl_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  sacl_core #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .MAX_WAYS     (MAX_WAYS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_mode   (in_tuser),
    .in_addr   (in_tdata),
    .res       (res),
    .res_ready (res_ready)
  );

  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res.valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && res_ready) begin
      out_outcome_r <= res.outcome;
      out_last_r    <= res.last;
      out_data_r    <= {res.evictions, res.misses, res.hits};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_outcome_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = out_data_r;

endmodule

[sim/set_assoc_cache_lru_sim_tb.sv]
// set_assoc_cache_lru_sim_tb: self-checking bench for the LRU cache hit/miss counter.
// Drives loads, stores and modifies over several cache geometries and idle mixes and
// checks every result item against an in-bench LRU cache model. Needs sacl_pkg and the RTL.
`timescale 1ns / 1ps

module set_assoc_cache_lru_sim_tb;
  import sacl_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 30;
  localparam int SET_BITS_MAX  = 8;
  localparam int WAYS_MAX      = 8;
  localparam int N_SETS        = 1 << SET_BITS_MAX;

  localparam logic [1:0] REG_SPARE  = 2'd3;
  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_STORE = 2'd1;
  localparam logic [1:0] MODE_ODD   = 2'd3;

  typedef struct {
    logic [1:0]  outcome;
    logic        last;
    logic [31:0] hits;
    logic [31:0] misses;
    logic [31:0] evicts;
  } access_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;   // [63:0] address
  logic [1:0]  in_tuser = '0;   // [1:0] mode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [95:0] out_tdata;       // [31:0] hit_total, [63:32] miss_total, [95:64] eviction_total
  logic [1:0]  out_tuser;       // [1:0] outcome
  logic        out_tlast;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  set_assoc_cache_lru_sim DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // cache model state
  bit          line_valid [N_SETS][WAYS_MAX];
  logic [63:0] line_tag   [N_SETS][WAYS_MAX];
  int unsigned line_age   [N_SETS][WAYS_MAX];
  logic [31:0] hit_count = '0;
  logic [31:0] miss_count = '0;
  logic [31:0] evict_count = '0;
  logic [3:0]  shadow_set_bits = RST_SET_BITS;
  logic [5:0]  shadow_off_bits = RST_OFF_BITS;
  logic [3:0]  shadow_ways = RST_WAYS;

  access_result_t pending_results[$];
  access_result_t head_result;

  int          send_idle = 0;
  int          recv_stall = 0;
  int          cycles = 0;
  int          mismatches = 0;
  int          items_sent = 0;
  int          results_seen = 0;
  int          settings_seen = 1;
  logic [63:0] phase_tag_base = '0;

  function automatic logic [31:0] sat_inc(logic [31:0] v);
    return (v == TOTAL_MAX) ? v : v + 32'd1;
  endfunction

  function automatic int eff_set_bits();
    return (shadow_set_bits > SET_BITS_MAX) ? SET_BITS_MAX : int'(shadow_set_bits);
  endfunction

  function automatic int eff_ways();
    if (shadow_ways == 0) return 1;
    return (shadow_ways > WAYS_MAX) ? WAYS_MAX : int'(shadow_ways);
  endfunction

  function automatic void touch_line(int s, int w, int ways);
    int unsigned old_age;
    old_age = line_valid[s][w] ? line_age[s][w] : 255;
    for (int j = 0; j < ways; j++) begin
      if (j != w && line_valid[s][j] && line_age[s][j] < old_age && line_age[s][j] < 255)
        line_age[s][j]++;
    end
    line_age[s][w] = 0;
  endfunction

  function automatic logic [1:0] cache_lookup(logic [63:0] addr);
    int          sb;
    int          bb;
    int          ways;
    int          s;
    int          victim;
    int unsigned oldest;
    logic [63:0] tg;
    sb   = eff_set_bits();
    bb   = int'(shadow_off_bits);
    ways = eff_ways();
    s    = int'((addr >> bb) & ((64'd1 << sb) - 64'd1));
    tg   = (sb + bb >= 64) ? 64'd0 : (addr >> (sb + bb));
    for (int j = 0; j < ways; j++) begin
      if (line_valid[s][j] && line_tag[s][j] == tg) begin
        touch_line(s, j, ways);
        hit_count = sat_inc(hit_count);
        return OUT_HIT;
      end
    end
    miss_count = sat_inc(miss_count);
    for (int j = 0; j < ways; j++) begin
      if (!line_valid[s][j]) begin
        touch_line(s, j, ways);
        line_valid[s][j] = 1'b1;
        line_tag[s][j]   = tg;
        return OUT_FILL;
      end
    end
    victim = 0;
    oldest = line_age[s][0];
    for (int j = 1; j < ways; j++) begin
      if (line_age[s][j] > oldest) begin
        oldest = line_age[s][j];
        victim = j;
      end
    end
    touch_line(s, victim, ways);
    line_tag[s][victim] = tg;
    evict_count = sat_inc(evict_count);
    return OUT_EVICT;
  endfunction

  // modify = load then store to the same line, two result items
  function automatic void predict_access(logic [1:0] mode, logic [63:0] addr);
    access_result_t r;
    r.outcome = cache_lookup(addr);
    r.last    = (mode != MODE_MODIFY);
    r.hits    = hit_count;
    r.misses  = miss_count;
    r.evicts  = evict_count;
    pending_results.push_back(r);
    if (mode == MODE_MODIFY) begin
      r.outcome = cache_lookup(addr);
      r.last    = 1'b1;
      r.hits    = hit_count;
      r.misses  = miss_count;
      r.evicts  = evict_count;
      pending_results.push_back(r);
    end
  endfunction

  // tags drawn from a small pool so lines get reused and evicted
  function automatic logic [63:0] pick_address();
    int          sb;
    int          ob;
    logic [63:0] tg;
    logic [63:0] st;
    logic [63:0] off;
    sb = eff_set_bits();
    ob = int'(shadow_off_bits);
    if ($urandom_range(99) < 10) return {$urandom, $urandom};
    tg  = phase_tag_base ^ 64'($urandom_range(eff_ways() + 2));
    st  = 64'($urandom_range(3)) & ((64'd1 << sb) - 64'd1);
    off = {$urandom, $urandom} & ((64'd1 << ob) - 64'd1);
    return (tg << (sb + ob)) | (st << ob) | off;
  endfunction

  task automatic send_access(input logic [1:0] mode, input logic [63:0] addr);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= addr;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    predict_access(mode, addr);
  endtask

  task automatic wait_results_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      REG_SET_BITS: shadow_set_bits = value[3:0];
      REG_OFF_BITS: shadow_off_bits = value[5:0];
      REG_WAYS:     shadow_ways     = value[3:0];
      default: ;
    endcase
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_geometry(input logic [3:0] sb, input logic [5:0] ob, input logic [3:0] wy);
    wait_results_drained();
    cfg_write(REG_SET_BITS, ($urandom & ~32'hF) | 32'(sb));
    cfg_write(REG_OFF_BITS, ($urandom & ~32'h3F) | 32'(ob));
    cfg_write(REG_WAYS, ($urandom & ~32'hF) | 32'(wy));
    settings_seen++;
  endtask

  // reset geometry: direct-mapped, 16 sets of 16-byte blocks
  task automatic test_basic_hit_fill_evict();
    send_idle  = 0;
    recv_stall = 0;
    send_access(MODE_LOAD, 64'h0);
    send_access(MODE_LOAD, 64'h0);
    send_access(MODE_STORE, 64'h10);
    send_access(MODE_MODIFY, '1);
    send_access(MODE_LOAD, 64'h100);
    send_access(MODE_ODD, 64'h100);
  endtask

  // out-of-range registers, wide split (tag always zero), ignored spare register
  task automatic test_config_limits();
    recv_stall = 24;
    set_geometry(4'd15, 6'd63, 4'd0);
    cfg_write(REG_SPARE, $urandom);
    send_access(MODE_MODIFY, 64'h0);
    send_access(MODE_LOAD, 64'h8000_0000_0000_0000);
    send_access(MODE_STORE, '1);
    send_access(MODE_LOAD, 64'h7FFF_FFFF_FFFF_FFFF);
  endtask

  // one fully associative set of eight ways: fill, touch, then evict in LRU order
  task automatic test_lru_order();
    send_idle  = 24;
    recv_stall = 24;
    set_geometry(4'd0, 6'd0, 4'd15);
    for (int i = 0; i < WAYS_MAX; i++) send_access(MODE_LOAD, 64'(i));
    send_access(MODE_STORE, 64'h0);
    send_access(MODE_LOAD, 64'h8);
    send_access(MODE_LOAD, 64'h1);
    send_access(MODE_STORE, '1);
  endtask

  task automatic run_phase(input int n, input logic [3:0] sb, input logic [5:0] ob,
                           input logic [3:0] wy, input int send_pct, input int stall_pct);
    set_geometry(sb, ob, wy);
    send_idle      = send_pct;
    recv_stall     = stall_pct;
    phase_tag_base = {$urandom, $urandom};
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) wait_results_drained();
      send_access(2'($urandom_range(3)), pick_address());
    end
  endtask

  task automatic test_random_traffic();
    run_phase(50, 4'd2, 6'd4, 4'd4, 0, 0);
    run_phase(50, 4'd0, 6'd0, 4'd8, 82, 0);
    run_phase(50, 4'd8, 6'd32, 4'd2, 0, 82);
    run_phase(50, 4'd1, 6'd6, 4'd3, 24, 24);
    run_phase(50, 4'd3, 6'd12, 4'd1, 0, 0);
    run_phase(50, 4'($urandom_range(15)), 6'($urandom_range(63)), 4'($urandom_range(15)), 82, 0);
    run_phase(50, 4'd15, 6'd63, 4'd15, 0, 82);
    run_phase(50, 4'($urandom_range(15)), 6'($urandom_range(63)), 4'($urandom_range(15)), 24, 24);
  endtask

  always @(posedge clk) out_tready <= ($urandom_range(99) >= recv_stall);

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("unexpected result item: outcome %0d", out_tuser);
        mismatches++;
      end else begin
        head_result = pending_results.pop_front();
        if (out_tuser !== head_result.outcome) begin
          $error("outcome: expected %0d, got %0d", head_result.outcome, out_tuser);
          mismatches++;
        end
        if (out_tlast !== head_result.last) begin
          $error("last: expected %0d, got %0d", head_result.last, out_tlast);
          mismatches++;
        end
        if (out_tdata[31:0] !== head_result.hits) begin
          $error("hit_total: expected %0d, got %0d", head_result.hits, out_tdata[31:0]);
          mismatches++;
        end
        if (out_tdata[63:32] !== head_result.misses) begin
          $error("miss_total: expected %0d, got %0d", head_result.misses, out_tdata[63:32]);
          mismatches++;
        end
        if (out_tdata[95:64] !== head_result.evicts) begin
          $error("eviction_total: expected %0d, got %0d", head_result.evicts, out_tdata[95:64]);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, pending_results.size());
      $display("set_assoc_cache_lru_sim_tb: done, errors");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_basic_hit_fill_evict();
    test_config_limits();
    test_lru_order();
    test_random_traffic();
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("checked %0d result items from %0d accesses over %0d cache geometries,",
             results_seen, items_sent, settings_seen);
    $display("with send gaps and output back-pressure mixed in; %0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("set_assoc_cache_lru_sim_tb: done, clean");
    end else begin
      $display("set_assoc_cache_lru_sim_tb: done, errors");
    end
    $finish;
  end

endmodule
